// File: hw/rtl/z80s_pkg.sv
// z80s_pkg: shared types and constants for the reduced z80 instruction executor
// holds the input and result word structs, operation codes, opcode values, t-state counts and reset values
// no dependencies

package z80s_pkg;

  // operation codes carried in each input word
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_IRQ  = 2'd1;
  localparam logic [1:0] OP_NMI  = 2'd2;

  // implemented opcodes
  localparam logic [7:0] OPC_NOP      = 8'h00;
  localparam logic [7:0] OPC_HALT     = 8'h76;
  localparam logic [7:0] OPC_LD_B_N   = 8'h06;
  localparam logic [7:0] OPC_LD_C_N   = 8'h0E;
  localparam logic [7:0] OPC_LD_D_N   = 8'h16;
  localparam logic [7:0] OPC_LD_E_N   = 8'h1E;
  localparam logic [7:0] OPC_LD_H_N   = 8'h26;
  localparam logic [7:0] OPC_LD_L_N   = 8'h2E;
  localparam logic [7:0] OPC_LD_A_N   = 8'h3E;
  localparam logic [7:0] OPC_LD_BC_NN = 8'h01;
  localparam logic [7:0] OPC_LD_DE_NN = 8'h11;
  localparam logic [7:0] OPC_LD_HL_NN = 8'h21;
  localparam logic [7:0] OPC_LD_SP_NN = 8'h31;
  localparam logic [7:0] OPC_JP_NN    = 8'hC3;
  localparam logic [7:0] OPC_CALL_NN  = 8'hCD;
  localparam logic [7:0] OPC_RET      = 8'hC9;
  localparam logic [7:0] OPC_DI       = 8'hF3;
  localparam logic [7:0] OPC_EI       = 8'hFB;
  localparam logic [7:0] OPC_OUT_N_A  = 8'hD3;
  localparam logic [7:0] OPC_IN_A_N   = 8'hDB;

  // t-state counts
  localparam logic [4:0] CYC_NONE = 5'd0;
  localparam logic [4:0] CYC_4    = 5'd4;
  localparam logic [4:0] CYC_7    = 5'd7;
  localparam logic [4:0] CYC_10   = 5'd10;
  localparam logic [4:0] CYC_11   = 5'd11;
  localparam logic [4:0] CYC_13   = 5'd13;
  localparam logic [4:0] CYC_17   = 5'd17;

  // reset values of the architectural state
  localparam logic [15:0] PC_RESET  = 16'h0000;
  localparam logic [15:0] SP_RESET  = 16'hFFFF;
  localparam logic [7:0]  ACC_RESET = 8'hFF;
  localparam logic [7:0]  FLAG_VAL  = 8'hFF;

  // refresh counter: low seven bits count, bit 7 is kept
  localparam logic [7:0] R_COUNT_MASK = 8'h7F;
  localparam logic [7:0] R_KEEP_MASK  = 8'h80;

  localparam int unsigned NUM_GP = 6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  opcode;
    logic [15:0] operand_word;
    logic [15:0] stack_word;
    logic [7:0]  io_in_data;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  cycle_count;
    logic [15:0] next_pc;
    logic        push_enable;
    logic [15:0] push_address;
    logic [15:0] push_data;
    logic        io_write_enable;
    logic        io_read_enable;
    logic [15:0] io_port;
    logic [7:0]  io_out_data;
    logic [7:0]  accumulator;
    logic        halted_now;
    logic        unknown_opcode;
  } out_word_t;

endpackage

// File: hw/rtl/z80_subset_instruction_execute.sv
// z80_subset_instruction_execute: top level of the reduced z80 instruction executor
// input register, single-pass decode and state update, result register
// depends on z80s_pkg

// One instruction or interrupt request per input word, one result word per input word.
// A word is taken into the input register, decoded and executed against the register
// file, and its result lands in the output register, which drives out_valid_o. The
// decode between the input and result registers is a single pass, so the sustained
// rate is one word per clock whenever the consumer does not stall. PC, SP, A, B..L,
// R, IFF1/IFF2 and the halt flag live here; memory and ports stay outside, the input
// word supplies operand bytes, the word at SP and IN data. The flag register is held
// at its reset value.
module z80_subset_instruction_execute (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  z80s_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output z80s_pkg::out_word_t  out_data_o
);

  // pipeline registers
  logic                in_valid_q;
  z80s_pkg::in_word_t  in_q;
  logic                out_valid_q;
  z80s_pkg::out_word_t out_q;
  z80s_pkg::out_word_t out_d;

  // architectural state
  logic [15:0] pc_q, pc_d;
  logic [15:0] sp_q, sp_d;
  logic [7:0]  acc_q, acc_d;
  logic [7:0]  gp_q [z80s_pkg::NUM_GP];
  logic [7:0]  refr_q, refr_d;
  logic        iff1_q, iff1_d;
  logic        iff2_q, iff2_d;
  logic        halt_q, halt_d;

  // register file write controls
  logic        gp_we_single;
  logic        gp_we_pair;
  logic [2:0]  gp_idx;
  logic [2:0]  gp_idx_lo;
  logic [7:0]  imm;
  logic [7:0]  hi_byte;
  logic [7:0]  refr_inc;

  logic out_ready;
  logic exec_fire;

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign exec_fire  = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign imm      = in_q.operand_word[7:0];
  assign hi_byte  = in_q.operand_word[15:8];
  assign refr_inc = ((refr_q + 8'd1) & z80s_pkg::R_COUNT_MASK) |
                    (refr_q & z80s_pkg::R_KEEP_MASK);
  assign gp_idx    = in_q.opcode[5:3];
  assign gp_idx_lo = {in_q.opcode[5:4], 1'b1};

  // decode and execute one word
  always_comb begin
    pc_d         = pc_q;
    sp_d         = sp_q;
    acc_d        = acc_q;
    refr_d       = refr_q;
    iff1_d       = iff1_q;
    iff2_d       = iff2_q;
    halt_d       = halt_q;
    gp_we_single = 1'b0;
    gp_we_pair   = 1'b0;
    out_d        = '0;

    case (in_q.operation)
      z80s_pkg::OP_IRQ: begin
        if (iff1_q) begin
          halt_d            = 1'b0;
          iff1_d            = 1'b0;
          iff2_d            = 1'b0;
          out_d.cycle_count = z80s_pkg::CYC_13;
        end
      end
      z80s_pkg::OP_NMI: begin
        halt_d = 1'b0;
        iff1_d = 1'b0;
      end
      z80s_pkg::OP_EXEC: begin
        refr_d = refr_inc;
        if (halt_q) begin
          out_d.cycle_count = z80s_pkg::CYC_4;
        end else begin
          case (in_q.opcode)
            z80s_pkg::OPC_NOP: begin
              pc_d              = pc_q + 16'd1;
              out_d.cycle_count = z80s_pkg::CYC_4;
            end
            z80s_pkg::OPC_HALT: begin
              halt_d            = 1'b1;
              pc_d              = pc_q + 16'd1;
              out_d.cycle_count = z80s_pkg::CYC_4;
            end
            z80s_pkg::OPC_LD_B_N, z80s_pkg::OPC_LD_C_N, z80s_pkg::OPC_LD_D_N,
            z80s_pkg::OPC_LD_E_N, z80s_pkg::OPC_LD_H_N, z80s_pkg::OPC_LD_L_N: begin
              gp_we_single      = 1'b1;
              pc_d              = pc_q + 16'd2;
              out_d.cycle_count = z80s_pkg::CYC_7;
            end
            z80s_pkg::OPC_LD_A_N: begin
              acc_d             = imm;
              pc_d              = pc_q + 16'd2;
              out_d.cycle_count = z80s_pkg::CYC_7;
            end
            z80s_pkg::OPC_LD_BC_NN, z80s_pkg::OPC_LD_DE_NN, z80s_pkg::OPC_LD_HL_NN: begin
              gp_we_pair        = 1'b1;
              pc_d              = pc_q + 16'd3;
              out_d.cycle_count = z80s_pkg::CYC_10;
            end
            z80s_pkg::OPC_LD_SP_NN: begin
              sp_d              = in_q.operand_word;
              pc_d              = pc_q + 16'd3;
              out_d.cycle_count = z80s_pkg::CYC_10;
            end
            z80s_pkg::OPC_JP_NN: begin
              pc_d              = in_q.operand_word;
              out_d.cycle_count = z80s_pkg::CYC_10;
            end
            z80s_pkg::OPC_CALL_NN: begin
              sp_d               = sp_q - 16'd2;
              out_d.push_enable  = 1'b1;
              out_d.push_address = sp_q - 16'd2;
              out_d.push_data    = pc_q + 16'd3;
              pc_d               = in_q.operand_word;
              out_d.cycle_count  = z80s_pkg::CYC_17;
            end
            z80s_pkg::OPC_RET: begin
              pc_d              = in_q.stack_word;
              sp_d              = sp_q + 16'd2;
              out_d.cycle_count = z80s_pkg::CYC_10;
            end
            z80s_pkg::OPC_DI: begin
              iff1_d            = 1'b0;
              iff2_d            = 1'b0;
              pc_d              = pc_q + 16'd1;
              out_d.cycle_count = z80s_pkg::CYC_4;
            end
            z80s_pkg::OPC_EI: begin
              iff1_d            = 1'b1;
              iff2_d            = 1'b1;
              pc_d              = pc_q + 16'd1;
              out_d.cycle_count = z80s_pkg::CYC_4;
            end
            z80s_pkg::OPC_OUT_N_A: begin
              out_d.io_write_enable = 1'b1;
              out_d.io_port         = {acc_q, imm};
              out_d.io_out_data     = acc_q;
              pc_d                  = pc_q + 16'd2;
              out_d.cycle_count     = z80s_pkg::CYC_11;
            end
            z80s_pkg::OPC_IN_A_N: begin
              out_d.io_read_enable = 1'b1;
              out_d.io_port        = {acc_q, imm};
              acc_d                = in_q.io_in_data;
              pc_d                 = pc_q + 16'd2;
              out_d.cycle_count    = z80s_pkg::CYC_11;
            end
            default: begin
              out_d.unknown_opcode = 1'b1;
              pc_d                 = pc_q + 16'd1;
              out_d.cycle_count    = z80s_pkg::CYC_4;
            end
          endcase
        end
      end
      default: begin
        // reserved operation: no effect, cycle_count set to CYC_NONE
        out_d.cycle_count = z80s_pkg::CYC_NONE;
      end
    endcase

    out_d.next_pc     = pc_d;
    out_d.accumulator = acc_d;
    out_d.halted_now  = halt_d;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  // architectural state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= z80s_pkg::PC_RESET;
      sp_q   <= z80s_pkg::SP_RESET;
      acc_q  <= z80s_pkg::ACC_RESET;
      refr_q <= '0;
      iff1_q <= 1'b0;
      iff2_q <= 1'b0;
      halt_q <= 1'b0;
    end else if (exec_fire) begin
      pc_q   <= pc_d;
      sp_q   <= sp_d;
      acc_q  <= acc_d;
      refr_q <= refr_d;
      iff1_q <= iff1_d;
      iff2_q <= iff2_d;
      halt_q <= halt_d;
    end
  end

  // general register file, b c d e h l
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < z80s_pkg::NUM_GP; i++) begin
        gp_q[i] <= '0;
      end
    end else if (exec_fire) begin
      if (gp_we_single) begin
        gp_q[gp_idx] <= imm;
      end
      if (gp_we_pair) begin
        gp_q[gp_idx]    <= hi_byte;
        gp_q[gp_idx_lo] <= imm;
      end
    end
  end

`ifndef SYNTHESIS
  // a stack push only comes from call
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.push_enable |-> out_q.cycle_count == z80s_pkg::CYC_17)
    else $error("push without call timing");

  // a word never requests both port directions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.io_write_enable && out_q.io_read_enable))
    else $error("both i/o directions requested");

  // an unknown opcode always costs four t-states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.unknown_opcode |-> out_q.cycle_count == z80s_pkg::CYC_4)
    else $error("unknown opcode timing");

  // while halted the program counter does not move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && halt_q |=> pc_q == $past(pc_q))
    else $error("pc moved while halted");

  // an execute word never wakes the processor from halt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && halt_q && in_q.operation == z80s_pkg::OP_EXEC |=> halt_q)
    else $error("halt cleared by an execute word");
`endif

endmodule
